// ===== rtl/dwc_pkg.sv =====
// dwc_pkg: shared types and constants for the depthwise conv1d stream block
// no dependencies
package dwc_pkg;
  localparam int MaxChannels = 1024;
  localparam int MaxTaps = 32;
  localparam int SampleWidth = 16;
  localparam int ChW = $clog2(MaxChannels);
  localparam int TapW = $clog2(MaxTaps);
  localparam int AccW = 2 * SampleWidth + TapW + 2;
  localparam int MemAw = ChW + TapW;

  localparam logic [1:0] RegChannels = 2'd0;
  localparam logic [1:0] RegTaps = 2'd1;
  localparam logic [1:0] RegLeft = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH,
    ST_OUT
  } dwc_state_t;

  typedef struct packed {
    logic load;
    logic clear_acc;
    logic mac_en;
    logic finish;
    logic advance;
  } dwc_cmd_t;

  typedef struct packed {
    logic is_sample;
    logic emit;
    logic tap_last;
  } dwc_status_t;
endpackage

// ===== rtl/dwc_ctrl.sv =====
// dwc_ctrl: sequencer for one item, load, multiply-accumulate walk, result hold
// depends on dwc_pkg
module dwc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  dwc_pkg::dwc_status_t status,
  output dwc_pkg::dwc_cmd_t    cmd
);
  import dwc_pkg::*;

  dwc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_tready = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if (!status.is_sample) begin
          state_nxt = ST_IDLE;
        end else if (!status.emit) begin
          cmd.advance = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cmd.clear_acc = 1'b1;
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        cmd.mac_en = 1'b1;
        if (status.tap_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        cmd.advance = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ===== rtl/dwc_datapath.sv =====
// dwc_datapath: history and weight memories, position counters, shared mac
// depends on dwc_pkg
module dwc_datapath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [10:0]              cfg_data,
  input  logic [47:0]              in_tdata,
  input  logic                     in_tuser,
  input  logic                     in_tlast,
  input  dwc_pkg::dwc_cmd_t        cmd,
  output dwc_pkg::dwc_status_t     status,
  output logic [47:0]              out_tdata
);
  import dwc_pkg::*;

  logic [10:0] chans_r;
  logic [5:0]  taps_r;
  logic [4:0]  left_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chans_r <= 11'd1;
      taps_r <= 6'd1;
      left_r <= 5'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegChannels: chans_r <= cfg_data;
        RegTaps: taps_r <= cfg_data[5:0];
        RegLeft: left_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // effective config
  logic [ChW:0]  nch;
  logic [TapW:0] k;
  logic [TapW:0] left_c;
  logic [TapW:0] look;
  always_comb begin
    if (chans_r == '0) nch = (ChW + 1)'(1);
    else if (chans_r > 11'(MaxChannels)) nch = (ChW + 1)'(MaxChannels);
    else nch = chans_r[ChW:0];
    if (taps_r == '0) k = (TapW + 1)'(1);
    else if (taps_r > 6'(MaxTaps)) k = (TapW + 1)'(MaxTaps);
    else k = taps_r[TapW:0];
    if ({1'b0, left_r} > k - 1'b1) left_c = k - 1'b1;
    else left_c = {1'b0, left_r};
    look = k - 1'b1 - left_c;
  end

  logic [ChW-1:0]  chpos_r;
  logic [15:0]     row_r;
  logic [TapW:0]   filled_r;
  logic [TapW-1:0] slot_r;

  logic [SampleWidth-1:0] hist_mem [MaxTaps*MaxChannels];
  logic [15:0]            wgt_mem [MaxChannels*MaxTaps];

  logic                   is_sample_r;
  logic [ChW-1:0]         ch_r;
  logic [TapW:0]          tap_r;
  logic [TapW:0]          d_r;
  logic                   rd_v_r;
  logic signed [SampleWidth-1:0] hq_r;
  logic signed [15:0]     wq_r;
  logic signed [SampleWidth+15:0] prod;
  logic signed [AccW-1:0] acc_r;
  logic [SampleWidth-1:0] res_r;
  logic [ChW-1:0]         och_r;
  logic [15:0]            orow_r;
  logic                   sat_r;

  logic start_now;
  assign start_now = in_tlast;

  // position of the loaded sample
  logic [15:0]     cur_row;
  logic [TapW:0]   cur_filled;
  assign cur_row = row_r;
  assign cur_filled = filled_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chpos_r <= '0;
      row_r <= '0;
      filled_r <= '0;
      slot_r <= '0;
      is_sample_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        is_sample_r <= in_tuser;
        if (in_tuser && start_now) begin
          chpos_r <= '0;
          row_r <= '0;
          filled_r <= '0;
        end
      end
      if (cmd.advance) begin
        if ({1'b0, ch_r} + 1'b1 >= nch) begin
          chpos_r <= '0;
          row_r <= row_r + 1'b1;
          slot_r <= slot_r + 1'b1;
          if (filled_r < (TapW + 1)'(MaxTaps)) filled_r <= filled_r + 1'b1;
        end else begin
          chpos_r <= ch_r + 1'b1;
        end
      end
    end
  end

  // memory writes and item capture
  logic [ChW-1:0] load_ch;
  assign load_ch = start_now ? '0 : chpos_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r <= load_ch;
      if (in_tuser) begin
        hist_mem[{slot_r, load_ch}] <= in_tdata[46:31];
      end else begin
        wgt_mem[{in_tdata[9:0], in_tdata[14:10]}] <= in_tdata[30:15];
      end
    end
  end

  assign status.is_sample = is_sample_r;
  assign status.emit = cur_filled >= look;
  assign status.tap_last = (tap_r == k - 1'b1);

  // tap walk: tap kk reads history at distance k-1-kk
  logic [TapW-1:0] rd_slot;
  logic            tap_ok;
  assign rd_slot = slot_r - d_r[TapW-1:0];
  assign tap_ok = d_r <= cur_filled;

  always_ff @(posedge clk) begin
    if (cmd.clear_acc) begin
      tap_r <= '0;
      d_r <= k - 1'b1;
    end else if (cmd.mac_en) begin
      tap_r <= tap_r + 1'b1;
      d_r <= d_r - 1'b1;
    end
    rd_v_r <= cmd.mac_en && tap_ok;
    hq_r <= hist_mem[{rd_slot, ch_r}];
    wq_r <= wgt_mem[{ch_r, tap_r[TapW-1:0]}];
  end

  assign prod = hq_r * wq_r;

  always_ff @(posedge clk) begin
    if (cmd.clear_acc) begin
      acc_r <= '0;
    end else if (rd_v_r) begin
      acc_r <= acc_r + AccW'(prod);
    end
  end

  // last product is added in the drain cycle
  logic signed [AccW-1:0] q;
  logic signed [AccW-1:0] hi_c, lo_c;
  assign q = acc_r >>> 15;
  assign hi_c = AccW'((1 << (SampleWidth - 1)) - 1);
  assign lo_c = -hi_c - 1;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      och_r <= ch_r;
      orow_r <= cur_row - 16'(look);
      if (q > hi_c) begin
        res_r <= hi_c[SampleWidth-1:0];
        sat_r <= 1'b1;
      end else if (q < lo_c) begin
        res_r <= lo_c[SampleWidth-1:0];
        sat_r <= 1'b1;
      end else begin
        res_r <= q[SampleWidth-1:0];
        sat_r <= 1'b0;
      end
    end
  end

  // result, out_channel, out_row, saturated
  assign out_tdata = {5'b0, sat_r, orow_r, och_r, res_r};
endmodule

// ===== rtl/depthwise_conv1d_stream.sv =====
// Depthwise causal 1-D convolution over interleaved channels, one shared
// multiply-accumulate. Weights and result-free samples pass load and prep; a
// sample with a result also walks the taps in use on the single mac, drains,
// finishes, holds output until taken, then takes the next item. Memories start
// undefined and are never cleared. tuser is func, tlast is start_sequence.
module depthwise_conv1d_stream (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // weight_channel, weight_tap, weight_value, sample, pad
  input  logic [47:0] in_tdata,
  // func
  input  logic        in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // result, out_channel, out_row, saturated, pad
  output logic [47:0] out_tdata
);
  import dwc_pkg::*;

  dwc_cmd_t    cmd;
  dwc_status_t status;

  dwc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .status(status), .cmd(cmd)
  );

  dwc_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .in_tlast(in_tlast), .cmd(cmd), .status(status), .out_tdata(out_tdata)
  );
endmodule

// ===== tb/tb_depthwise_conv1d_stream.sv =====
// testbench for depthwise_conv1d_stream: drives weight and sample transactions,
// predicts each filtered result in a scoreboard class and checks the output stream
// depends on rtl/dwc_pkg.sv and rtl/depthwise_conv1d_stream.sv
`timescale 1ns / 100ps

module tb_depthwise_conv1d_stream;
  import dwc_pkg::*;

  localparam bit FuncWeight = 1'b0;
  localparam bit FuncSample = 1'b1;
  localparam int IdleLimit = 5000;
  localparam int DrainCycles = 60;
  localparam int ItemTarget = 1450;

  typedef struct {
    logic [15:0] value;
    logic [9:0]  chan;
    logic [15:0] row;
    logic        sat;
  } conv_out_t;

  class conv_scoreboard;
    int unsigned chan_reg, taps_reg, left_reg;
    shortint     history[MaxTaps * MaxChannels];
    shortint     coeffs[MaxChannels * MaxTaps];
    int unsigned chan_pos, rows_filled, ring;
    logic [15:0] row_cnt;
    conv_out_t   pending[$];
    int          errors;

    function new();
      chan_reg = 1;
      taps_reg = 1;
      left_reg = 0;
      chan_pos = 0;
      rows_filled = 0;
      ring = 0;
      row_cnt = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, int unsigned val);
      case (idx)
        RegChannels: chan_reg = val & 11'h7ff;
        RegTaps:     taps_reg = val & 6'h3f;
        RegLeft:     left_reg = val & 5'h1f;
        default: ;
      endcase
    endfunction

    function void note_input(bit func, logic [9:0] wc, logic [4:0] wt, logic [15:0] wv,
                             logic [15:0] smp, bit start);
      int unsigned nch, k, left, look, ch, d, slot;
      longint acc, q;
      conv_out_t o;
      if (func == FuncWeight) begin
        coeffs[wc * MaxTaps + wt] = wv;
        return;
      end
      if (start) begin
        chan_pos = 0;
        row_cnt = '0;
        rows_filled = 0;
      end
      nch = chan_reg == 0 ? 1 : (chan_reg > MaxChannels ? MaxChannels : chan_reg);
      k = taps_reg == 0 ? 1 : (taps_reg > MaxTaps ? MaxTaps : taps_reg);
      left = left_reg > k - 1 ? k - 1 : left_reg;
      look = k - 1 - left;
      ch = chan_pos >= MaxChannels ? 0 : chan_pos;
      history[ring * MaxChannels + ch] = smp;
      if (rows_filled >= look) begin
        acc = 0;
        for (int kk = 0; kk < k; kk++) begin
          d = k - 1 - kk;
          if (d <= rows_filled) begin
            slot = (ring + MaxTaps - d) % MaxTaps;
            acc += longint'(history[slot * MaxChannels + ch]) *
                   longint'(coeffs[ch * MaxTaps + kk]);
          end
        end
        q = acc >>> 15;
        o.sat = 1'b0;
        if (q > 32767) begin
          q = 32767;
          o.sat = 1'b1;
        end
        if (q < -32768) begin
          q = -32768;
          o.sat = 1'b1;
        end
        o.value = q[15:0];
        o.chan = ch[9:0];
        o.row = row_cnt - look[15:0];
        pending.push_back(o);
      end
      if (ch + 1 >= nch) begin
        chan_pos = 0;
        row_cnt = row_cnt + 16'd1;
        ring = (ring + 1) % MaxTaps;
        if (rows_filled < MaxTaps) rows_filled++;
      end else begin
        chan_pos = ch + 1;
      end
    endfunction

    function void check_result(logic [47:0] d);
      conv_out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transaction %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[15:0] !== e.value) begin
        $error("result: expected %0d got %0d", $signed(e.value), $signed(d[15:0]));
        errors++;
      end
      if (d[25:16] !== e.chan) begin
        $error("out_channel: expected %0d got %0d", e.chan, d[25:16]);
        errors++;
      end
      if (d[41:26] !== e.row) begin
        $error("out_row: expected %0d got %0d", e.row, d[41:26]);
        errors++;
      end
      if (d[42] !== e.sat) begin
        $error("saturated: expected %0d got %0d", e.sat, d[42]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  conv_scoreboard sb = new();
  bit   quiet;
  bit   hold_req;
  int   items_sent;
  int   idle_cycles;
  bit   coeff_written[MaxChannels * MaxTaps];

  depthwise_conv1d_stream dut (.*);

  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  // sink side: random back pressure plus an occasional long hold-off
  initial begin
    int n;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        n = 400;
      end else if (quiet) begin
        n = 0;
      end else begin
        n = $urandom_range(0, 99) < 75 ? 0 :
            ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(10, 50));
      end
      @(negedge clk);
      if (n > 0) begin
        out_tready = 1'b0;
        repeat (n - 1) @(negedge clk);
        @(negedge clk);
      end
      out_tready = 1'b1;
      repeat ($urandom_range(0, 15)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) sb.check_result(out_tdata);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(bit func, logic [9:0] wc, logic [4:0] wt, logic [15:0] wv,
                           logic [15:0] smp, bit start);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = func;
    in_tlast = start;
    in_tdata = {1'b0, smp, wv, wt, wc};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    sb.note_input(func, wc, wt, wv, smp, start);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_coeff(int c, int t);
    coeff_written[c * MaxTaps + t] = 1'b1;
    send_item(FuncWeight, c[9:0], t[4:0], pick_value(), 16'($urandom()), $urandom_range(0, 1));
  endtask

  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val[10:0];
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // one setting: registers, the coefficients it needs, then sample transactions
  task automatic run_phase(int unsigned chv, int unsigned tapv, int unsigned leftv,
                           int nsamp, bit keep_seq, bit hold);
    int nch, k, touched, c;
    bit start;
    wait_idle();
    write_reg(RegChannels, chv);
    write_reg(RegTaps, tapv);
    write_reg(RegLeft, leftv);
    nch = chv == 0 ? 1 : (chv > MaxChannels ? MaxChannels : chv);
    k = tapv == 0 ? 1 : (tapv > MaxTaps ? MaxTaps : tapv);
    touched = nch < nsamp ? nch : nsamp;
    for (int i = 0; i < touched; i++)
      for (int t = 0; t < k; t++)
        if (!coeff_written[i * MaxTaps + t] || $urandom_range(0, 7) == 0) write_coeff(i, t);
    if (hold) hold_req = 1'b1;
    for (int i = 0; i < nsamp; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        c = $urandom_range(0, touched - 1);
        write_coeff(c, $urandom_range(0, k - 1));
      end
      if ($urandom_range(0, 39) == 0) write_coeff($urandom_range(0, 1023), $urandom_range(0, 31));
      start = (i == 0 && !keep_seq) || $urandom_range(0, 79) == 0;
      send_item(FuncSample, 10'($urandom()), 5'($urandom()), 16'($urandom()),
                pick_value(), start);
    end
  endtask

  initial begin
    int chv, tapv;
    items_sent = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    write_coeff(1023, 31);
    run_phase(1, 1, 0, 12, 1'b0, 1'b0);
    run_phase(0, 0, 31, 10, 1'b0, 1'b0);
    run_phase(2047, 1, 0, 24, 1'b0, 1'b0);
    run_phase(1, 63, 31, 40, 1'b0, 1'b0);
    run_phase(1, 32, 0, 45, 1'b0, 1'b0);
    run_phase(5, 2, 0, 7, 1'b0, 1'b0);
    // shrink the channel count mid-row and carry on without a start flag
    run_phase(3, 2, 0, 12, 1'b1, 1'b0);
    while (items_sent < ItemTarget - 140) begin
      quiet = $urandom_range(0, 5) == 0;
      chv = $urandom_range(0, 9) == 0 ? $urandom_range(7, 12) : $urandom_range(1, 6);
      tapv = $urandom_range(1, 32);
      run_phase(chv, tapv, $urandom_range(0, 31), $urandom_range(30, 90), 1'b0,
                $urandom_range(0, 5) == 0);
    end
    quiet = 1'b0;
    run_phase(2, 8, 3, 60, 1'b0, 1'b1);
    in_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule
